FILE: rtl/assert_macros.svh
// Assertion macros for the echo tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ERTT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ERTT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ertt_pkg.sv
// Types, codes and constants for the echo probe RTT / timeout tracker.
`default_nettype none

package ertt_pkg;

    // Default in-flight window depth
    localparam int WINDOW_DEPTH_DEF = 16;
    // Most results one tick may produce
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);
    localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);
    // Probe RAM word: route id over send time
    localparam int RAM_W       = 64;
    // Timeout register reset value (ms)
    localparam logic [31:0] TIMEOUT_RESET = 32'd2000;

    // Input modes
    localparam logic [1:0] MODE_ISSUE    = 2'd0;
    localparam logic [1:0] MODE_RESPONSE = 2'd1;
    localparam logic [1:0] MODE_TICK     = 2'd2;
    localparam logic [1:0] MODE_PEER     = 2'd3;

    // Result kinds
    localparam logic [2:0] KIND_PING       = 3'd0;
    localparam logic [2:0] KIND_PONG       = 3'd1;
    localparam logic [2:0] KIND_SUCCESS    = 3'd2;
    localparam logic [2:0] KIND_TIMEOUT    = 3'd3;
    localparam logic [2:0] KIND_UNRESOLVED = 3'd4;
    localparam logic [2:0] KIND_OVERFLOW   = 3'd5;

    // Command classes decided by the front
    typedef enum logic [2:0] {
        OP_ISSUE,
        OP_UNRESOLVED,
        OP_RESPONSE,
        OP_TICK,
        OP_PONG
    } op_t;

    // Back sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RESP,
        BK_SCAN,
        BK_CHECK
    } bk_state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] route_tag;
        logic        address_resolved;
        logic [31:0] peer_host;
        logic [15:0] peer_port;
        logic [31:0] sequence_number;
        logic [31:0] now_ms;
    } in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] route_tag_out;
        logic [31:0] sequence_out;
        logic [31:0] host_out;
        logic [15:0] port_out;
        logic [31:0] rtt_or_timeout;
        logic        last;
    } res_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] route_tag;
        logic [31:0] peer_host;
        logic [15:0] peer_port;
        logic [31:0] sequence_number;
        logic [31:0] now_ms;
    } q_entry_t;

endpackage

`default_nettype wire

FILE: rtl/echo_rtt_timeout_tracker_core.sv
// Top level of the echo probe round-trip time and timeout tracker.
`default_nettype none

// Echo probe tracker. An input beat is taken when start is high and busy is
// low; a two-deep command queue sits between the front, which classifies
// beats, and the back, which owns the probe window. Results appear on result
// for exactly one cycle with result_valid high and cannot be held off, so the
// receiver must take every beat. Issue, pong and unresolved items pass
// through the queue and result register; the idle back takes one per cycle.
// A matching response is answered from BK_RESP after the registered RAM
// read. A tick retires entries from the oldest on: answered ones in BK_SCAN,
// unanswered ones after a read on the single RAM port in BK_CHECK, until the
// window is empty, one has not expired or MAX_RESULTS timed out. Busy rises
// while the queue is full. Tick timeouts are held back by one result so the
// final one can carry last. The user must write timeout_ms through cfg_wr_en
// and cfg_wr_data only while the block is idle; this is not enforced.

`include "assert_macros.svh"

module echo_rtt_timeout_tracker_core
    import ertt_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire in_t         item,
    output logic             busy,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    output logic             result_valid,
    output res_t             result
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    logic              pop;
    logic              head_valid;
    q_entry_t          head;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [RAM_W-1:0]  ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [RAM_W-1:0]  ram_rdata;
    logic [CW-1:0]     in_flight;
    logic              back_idle;

    // Accept and classify
    ertt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .busy       (busy),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Probe route and send time store
    ertt_ram #(
        .WIDTH (RAM_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_probe_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Window state and result generation
    ertt_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .result_valid (result_valid),
        .result       (result),
        .in_flight    (in_flight),
        .idle         (back_idle)
    );

    // Checks
    `ERTT_ASSERT_IMP(a_inflight_bound, 1'b1, in_flight <= CW'(WINDOW_DEPTH), "window overfilled")
    `ERTT_ASSERT_NXT(a_inflight_step, 1'b1, (in_flight == $past(in_flight)) || (in_flight == $past(in_flight) + 1'b1) || (in_flight + 1'b1 == $past(in_flight)), "in-flight count jumped")
    `ERTT_ASSERT_IMP(a_last_pending, result_valid && !result.last, !back_idle, "non-last beat with tick finished")

endmodule

`default_nettype wire

FILE: rtl/ertt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ertt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/ertt_front.sv
// Front end: accepts input beats, classifies them and queues commands.
`default_nettype none

module ertt_front
    import ertt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire in_t      item,
    output logic          busy,
    input  wire logic     pop,
    output logic          head_valid,
    output q_entry_t      head
);

    q_entry_t         queue_reg [QUEUE_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]  count_reg, count_next;
    logic             push;
    logic             do_pop;
    q_entry_t         entry;

    // Classify the incoming beat
    always_comb
    begin
        entry.route_tag       = item.route_tag;
        entry.peer_host       = item.peer_host;
        entry.peer_port       = item.peer_port;
        entry.sequence_number = item.sequence_number;
        entry.now_ms          = item.now_ms;
        case (item.mode)
            MODE_ISSUE:    entry.op = item.address_resolved ? OP_ISSUE : OP_UNRESOLVED;
            MODE_RESPONSE: entry.op = OP_RESPONSE;
            MODE_TICK:     entry.op = OP_TICK;
            MODE_PEER:     entry.op = OP_PONG;
            default:       entry.op = OP_PONG;
        endcase
    end

    assign busy       = (count_reg == Q_CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = queue_reg[rd_ptr_reg];
    assign push       = start && !busy;
    assign do_pop     = pop && head_valid;

    // Queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ertt_back.sv
// Back end: probe window state, response matching and tick retirement.
`default_nettype none

module ertt_back
    import ertt_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [31:0]                     cfg_wr_data,
    input  wire logic                            head_valid,
    input  wire q_entry_t                        head,
    output logic                                 pop,
    output logic                                 ram_we,
    output logic [$clog2(WINDOW_DEPTH)-1:0]      ram_waddr,
    output logic [RAM_W-1:0]                     ram_wdata,
    output logic [$clog2(WINDOW_DEPTH)-1:0]      ram_raddr,
    input  wire logic [RAM_W-1:0]                ram_rdata,
    output logic                                 result_valid,
    output res_t                                 result,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0]    in_flight,
    output logic                                 idle
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CW:0]   DEPTH_X = (CW+1)'(WINDOW_DEPTH);
    localparam logic [CW-1:0] FULL_C  = CW'(WINDOW_DEPTH);
    localparam logic [RES_CNT_W-1:0] MAX_C = RES_CNT_W'(MAX_RESULTS);

    bk_state_t                 state_reg, state_next;
    logic [AW-1:0]             oldest_reg, oldest_next;
    logic [CW-1:0]             inflight_reg, inflight_next;
    logic [WINDOW_DEPTH-1:0]   answered_reg, answered_next;
    logic [31:0]               next_seq_reg, next_seq_next;
    logic [RES_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [31:0]               timeout_reg, timeout_next;
    logic                      res_valid_reg, res_valid_next;
    logic                      pend_valid_reg, pend_valid_next;
    res_t                      res_reg, res_next;
    res_t                      pend_reg, pend_next;
    q_entry_t                  cur_reg, cur_next;

    logic [CW:0]               tail_sum;
    logic [AW-1:0]             tail_slot;
    logic [31:0]               first_seq;
    logic [31:0]               seq_offset;
    logic                      resp_hit;
    logic [CW:0]               resp_sum;
    logic [AW-1:0]             resp_slot;
    logic [AW-1:0]             oldest_inc;
    logic [31:0]               age;
    logic                      finish;
    logic                      retire;

    // Slot arithmetic, modulo the window depth
    always_comb
    begin
        tail_sum   = {{(CW+1-AW){1'b0}}, oldest_reg} + {1'b0, inflight_reg};
        tail_slot  = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : AW'(tail_sum);
        first_seq  = next_seq_reg - 32'(inflight_reg);
        seq_offset = head.sequence_number - first_seq;
        resp_hit   = (seq_offset < 32'(inflight_reg));
        resp_sum   = {{(CW+1-AW){1'b0}}, oldest_reg} + {1'b0, seq_offset[CW-1:0]};
        resp_slot  = (resp_sum >= DEPTH_X) ? AW'(resp_sum - DEPTH_X) : AW'(resp_sum);
        oldest_inc = (oldest_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
        age        = cur_reg.now_ms - ram_rdata[31:0];
    end

    // Sequencer: next state and datapath controls
    always_comb
    begin
        state_next      = state_reg;
        oldest_next     = oldest_reg;
        inflight_next   = inflight_reg;
        answered_next   = answered_reg;
        next_seq_next   = next_seq_reg;
        cnt_next        = cnt_reg;
        timeout_next    = cfg_wr_en ? cfg_wr_data : timeout_reg;
        res_valid_next  = 1'b0;
        res_next        = res_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        cur_next        = cur_reg;
        pop             = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = tail_slot;
        ram_wdata       = {head.route_tag, head.now_ms};
        ram_raddr       = oldest_reg;
        finish          = 1'b0;
        retire          = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    case (head.op)
                        OP_UNRESOLVED:
                        begin
                            res_valid_next = 1'b1;
                            res_next = '{KIND_UNRESOLVED, head.route_tag, 32'd0, 32'd0,
                                         16'd0, timeout_reg, 1'b1};
                        end
                        OP_ISSUE:
                        begin
                            res_valid_next = 1'b1;
                            if (inflight_reg == FULL_C)
                            begin
                                res_next = '{KIND_OVERFLOW, head.route_tag, 32'd0, 32'd0,
                                             16'd0, timeout_reg, 1'b1};
                            end
                            else
                            begin
                                ram_we                   = 1'b1;
                                answered_next[tail_slot] = 1'b0;
                                inflight_next            = inflight_reg + 1'b1;
                                next_seq_next            = next_seq_reg + 32'd1;
                                res_next = '{KIND_PING, head.route_tag, next_seq_reg,
                                             head.peer_host, head.peer_port, timeout_reg,
                                             1'b1};
                            end
                        end
                        OP_RESPONSE:
                        begin
                            ram_raddr = resp_slot;
                            if (resp_hit && !answered_reg[resp_slot])
                            begin
                                answered_next[resp_slot] = 1'b1;
                                state_next               = BK_RESP;
                            end
                        end
                        OP_TICK:
                        begin
                            cnt_next   = '0;
                            state_next = BK_SCAN;
                        end
                        OP_PONG:
                        begin
                            res_valid_next = 1'b1;
                            res_next = '{KIND_PONG, 32'd0, head.sequence_number,
                                         head.peer_host, head.peer_port, timeout_reg, 1'b1};
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end

            BK_RESP:
            begin
                res_valid_next = 1'b1;
                res_next = '{KIND_SUCCESS, ram_rdata[63:32], cur_reg.sequence_number,
                             32'd0, 16'd0, cur_reg.now_ms - ram_rdata[31:0], 1'b1};
                state_next = BK_IDLE;
            end

            BK_SCAN:
            begin
                // answered entries retire without a RAM read
                if (inflight_reg == '0)
                begin
                    finish = 1'b1;
                end
                else if (answered_reg[oldest_reg])
                begin
                    retire = 1'b1;
                end
                else
                begin
                    state_next = BK_CHECK;
                end
            end

            BK_CHECK:
            begin
                if ((age < timeout_reg) || (cnt_reg == MAX_C))
                begin
                    finish = 1'b1;
                end
                else
                begin
                    // hold the newest timeout back until we know if it is the last
                    if (pend_valid_reg)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = pend_reg;
                        res_next.last  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_next = '{KIND_TIMEOUT, ram_rdata[63:32], 32'd0, 32'd0, 16'd0,
                                  timeout_reg, 1'b0};
                    cnt_next   = cnt_reg + 1'b1;
                    retire     = 1'b1;
                    state_next = BK_SCAN;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        // Retire the oldest entry
        if (retire)
        begin
            answered_next[oldest_reg] = 1'b0;
            oldest_next               = oldest_inc;
            inflight_next             = inflight_reg - 1'b1;
        end

        // End of tick: flush the held result as the last beat
        if (finish)
        begin
            state_next = BK_IDLE;
            if (pend_valid_reg)
            begin
                res_valid_next  = 1'b1;
                res_next        = pend_reg;
                res_next.last   = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            oldest_reg     <= '0;
            inflight_reg   <= '0;
            answered_reg   <= '0;
            next_seq_reg   <= '0;
            cnt_reg        <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            res_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            oldest_reg     <= oldest_next;
            inflight_reg   <= inflight_next;
            answered_reg   <= answered_next;
            next_seq_reg   <= next_seq_next;
            cnt_reg        <= cnt_next;
            timeout_reg    <= timeout_next;
            res_valid_reg  <= res_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        pend_reg <= pend_next;
        cur_reg  <= cur_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign in_flight    = inflight_reg;
    assign idle         = (state_reg == BK_IDLE);

endmodule

`default_nettype wire

FILE: bench/echo_rtt_timeout_tracker_core_test.sv
// Self-checking bench for the echo probe RTT / timeout tracker core.
`timescale 1ns / 100ps

module echo_rtt_timeout_tracker_core_test;
    import ertt_pkg::*;

    localparam int DEPTH      = WINDOW_DEPTH_DEF;
    localparam int QUIET      = 60;
    localparam int CYCLE_CAP  = 200000;
    localparam int PHASE_LEN  = 33;

    // DUT signals, inputs known from time zero
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    in_t         item        = '0;
    logic        busy;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        result_valid;
    res_t        result;

    // Shadow of the probe window
    logic [31:0] win_route    [DEPTH];
    logic [31:0] win_sent     [DEPTH];
    logic        win_answered [DEPTH];
    logic [3:0]  win_oldest;
    logic [4:0]  win_count;
    logic [31:0] win_next_seq;
    logic [31:0] cur_timeout;

    // Results predicted but not yet seen
    res_t        awaited_results [$];
    res_t        front_result;

    // Run bookkeeping
    int          errors        = 0;
    int          beats_sent    = 0;
    int          results_seen  = 0;
    int          settings_used = 0;
    int          kind_seen [6];
    int          burst_left    = 0;
    int          cycle_count   = 0;
    logic [31:0] cur_ms;

    echo_rtt_timeout_tracker_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result_valid (result_valid),
        .result       (result)
    );

    // 10 ns clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("%0t ns: watchdog expired with %0d results outstanding",
                     $time, awaited_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic res_t make_result(input logic [2:0] kind,
                                         input logic [31:0] route,
                                         input logic [31:0] seq,
                                         input logic [31:0] host,
                                         input logic [15:0] port,
                                         input logic [31:0] val);
        res_t r;
        r.kind           = kind;
        r.route_tag_out  = route;
        r.sequence_out   = seq;
        r.host_out       = host;
        r.port_out       = port;
        r.rtt_or_timeout = val;
        r.last           = 1'b0;
        return r;
    endfunction

    function automatic in_t make_beat(input logic [1:0] mode,
                                      input logic [31:0] route,
                                      input logic resolved,
                                      input logic [31:0] host,
                                      input logic [15:0] port,
                                      input logic [31:0] seq,
                                      input logic [31:0] now);
        in_t b;
        b.mode             = mode;
        b.route_tag        = route;
        b.address_resolved = resolved;
        b.peer_host        = host;
        b.peer_port        = port;
        b.sequence_number  = seq;
        b.now_ms           = now;
        return b;
    endfunction

    // Advance the shadow window by one accepted beat and queue its results
    task automatic predict_results(input in_t b);
        res_t        batch [$];
        logic [3:0]  slot;
        logic [31:0] first;
        logic [31:0] offset;
        res_t        r;
        case (b.mode)
            MODE_ISSUE:
            begin
                if (!b.address_resolved)
                    batch.insert(batch.size(), make_result(KIND_UNRESOLVED, b.route_tag,
                                                           '0, '0, '0, cur_timeout));
                else if (win_count >= DEPTH)
                    batch.insert(batch.size(), make_result(KIND_OVERFLOW, b.route_tag,
                                                           '0, '0, '0, cur_timeout));
                else
                begin
                    slot               = win_oldest + win_count[3:0];
                    win_route[slot]    = b.route_tag;
                    win_sent[slot]     = b.now_ms;
                    win_answered[slot] = 1'b0;
                    batch.insert(batch.size(), make_result(KIND_PING, b.route_tag,
                                                           win_next_seq, b.peer_host,
                                                           b.peer_port, cur_timeout));
                    win_count    = win_count + 1'b1;
                    win_next_seq = win_next_seq + 1;
                end
            end
            MODE_RESPONSE:
            begin
                first  = win_next_seq - 32'(win_count);
                offset = b.sequence_number - first;
                if (offset < 32'(win_count))
                begin
                    slot = win_oldest + offset[3:0];
                    if (!win_answered[slot])
                    begin
                        win_answered[slot] = 1'b1;
                        batch.insert(batch.size(),
                                     make_result(KIND_SUCCESS, win_route[slot],
                                                 b.sequence_number, '0, '0,
                                                 b.now_ms - win_sent[slot]));
                    end
                end
            end
            MODE_TICK:
            begin
                // Retire from the oldest entry while answered or expired, up to MAX_RESULTS timeouts
                while (win_count > 0)
                begin
                    slot = win_oldest;
                    if (!win_answered[slot])
                    begin
                        if ((b.now_ms - win_sent[slot]) < cur_timeout)
                            break;
                        if (batch.size() >= MAX_RESULTS)
                            break;
                        batch.insert(batch.size(), make_result(KIND_TIMEOUT, win_route[slot],
                                                               '0, '0, '0, cur_timeout));
                    end
                    win_answered[slot] = 1'b0;
                    win_oldest         = slot + 1'b1;
                    win_count          = win_count - 1'b1;
                end
            end
            default:
            begin
                batch.insert(batch.size(), make_result(KIND_PONG, '0, b.sequence_number,
                                                       b.peer_host, b.peer_port,
                                                       cur_timeout));
            end
        endcase
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
        begin
            r = batch[i];
            awaited_results.insert(awaited_results.size(), r);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Compare every result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (result.kind < 6)
                kind_seen[result.kind]++;
            if (awaited_results.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual %h", $time, result);
            end
            else
            begin
                front_result = awaited_results.pop_front();
                check_field("kind", 32'(front_result.kind), 32'(result.kind));
                check_field("route_tag_out", front_result.route_tag_out,
                            result.route_tag_out);
                check_field("sequence_out", front_result.sequence_out, result.sequence_out);
                check_field("host_out", front_result.host_out, result.host_out);
                check_field("port_out", 32'(front_result.port_out), 32'(result.port_out));
                check_field("rtt_or_timeout", front_result.rtt_or_timeout,
                            result.rtt_or_timeout);
                check_field("last", 32'(front_result.last), 32'(result.last));
            end
        end
    end

    // Send one beat after a random gap; start stays high when the next follows at once
    task automatic send_beat(input in_t b);
        int gap;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 12);
            if ($urandom_range(0, 14) == 0)
                burst_left = $urandom_range(5, 20);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_results(b);
        beats_sent++;
    endtask

    // Let the block go quiet, then load a new timeout
    task automatic write_timeout(input logic [31:0] value);
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (QUIET) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_timeout = value;
        settings_used++;
    endtask

    // Random beat: mostly well-formed traffic against the current window
    function automatic in_t next_random_beat();
        int          pick;
        logic [1:0]  mode;
        logic [31:0] seq;
        logic [31:0] now;
        logic [31:0] first;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            mode = MODE_ISSUE;
        else if (pick < 65)
            mode = MODE_RESPONSE;
        else if (pick < 90)
            mode = MODE_TICK;
        else
            mode = MODE_PEER;

        cur_ms = cur_ms + $urandom_range(0, 400);
        now    = cur_ms;
        seq    = $urandom;
        first  = win_next_seq - 32'(win_count);

        if (mode == MODE_RESPONSE && win_count > 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                seq = first + $urandom_range(0, win_count - 1);
            else if (pick < 85)
                seq = win_next_seq;
            else if (pick < 90)
                seq = first - 1;
        end
        // Put ticks right on the expiry edge of the oldest probe
        if (mode == MODE_TICK && win_count > 0 && $urandom_range(0, 99) < 40)
            now = win_sent[win_oldest] + cur_timeout + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 99) < 5)
            now = $urandom;
        return make_beat(mode, $urandom, ($urandom_range(0, 99) < 85), $urandom,
                         16'($urandom), seq, now);
    endfunction

    // Tick on an empty window gives nothing
    task automatic test_idle_tick();
        send_beat(make_beat(MODE_TICK, '0, 1'b0, '0, '0, '0, cur_ms));
    endtask

    // Peer pings at both field extremes
    task automatic test_peer_ping();
        send_beat(make_beat(MODE_PEER, '1, 1'b1, '1, '1, '1, '1));
        send_beat(make_beat(MODE_PEER, '0, 1'b0, '0, '0, '0, '0));
    endtask

    // Unresolved address uses no sequence number
    task automatic test_unresolved();
        send_beat(make_beat(MODE_ISSUE, '1, 1'b0, '1, '1, '1, cur_ms));
    endtask

    // Fill the window, then one more issue is refused
    task automatic test_fill_window();
        for (int i = 0; i <= DEPTH; i++)
            send_beat(make_beat(MODE_ISSUE, $urandom, 1'b1, $urandom, 16'($urandom),
                                $urandom, cur_ms + 32'(i * 16)));
    endtask

    // Success across the time wrap, duplicate answer, answer past the window
    task automatic test_responses();
        send_beat(make_beat(MODE_RESPONSE, '0, 1'b0, '0, '0, 32'd0, 32'h20));
        send_beat(make_beat(MODE_RESPONSE, '0, 1'b0, '0, '0, 32'd0, 32'h40));
        send_beat(make_beat(MODE_RESPONSE, '0, 1'b0, '0, '0, 32'(DEPTH), 32'h60));
    endtask

    // Tick late enough that every remaining probe times out
    task automatic test_timeout_sweep();
        send_beat(make_beat(MODE_TICK, '0, 1'b0, '0, '0, '0,
                            cur_ms + 32'((DEPTH - 1) * 16) + cur_timeout));
        cur_ms = cur_ms + 32'(DEPTH * 16) + cur_timeout;
    endtask

    // Random traffic under several timeout settings, extremes included
    task automatic test_random_phases();
        logic [31:0] settings [6];
        in_t         b;
        settings[0] = 32'd1;
        settings[1] = 32'hFFFF_FFFF;
        settings[2] = 32'd0;
        settings[3] = 32'd300;
        settings[4] = $urandom_range(1000, 100000);
        settings[5] = TIMEOUT_RESET;
        foreach (settings[p])
        begin
            write_timeout(settings[p]);
            repeat (PHASE_LEN)
            begin
                b = next_random_beat();
                send_beat(b);
            end
        end
    endtask

    initial
    begin
        // Reset the shadow along with the block
        foreach (win_answered[i])
        begin
            win_route[i]    = '0;
            win_sent[i]     = '0;
            win_answered[i] = 1'b0;
        end
        foreach (kind_seen[i])
            kind_seen[i] = 0;
        win_oldest   = '0;
        win_count    = '0;
        win_next_seq = '0;
        cur_timeout  = TIMEOUT_RESET;
        cur_ms       = 32'hFFFF_FF00;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_tick();
        test_peer_ping();
        test_unresolved();
        test_fill_window();
        test_responses();
        test_timeout_sweep();
        test_random_phases();

        // Drain and settle
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (QUIET) @(posedge clk);

        $display("Sent %0d beats over %0d timeout settings; checked %0d results",
                 beats_sent, settings_used + 1, results_seen);
        $display("  pings %0d, pongs %0d, successes %0d, timeouts %0d, unresolved %0d, refused %0d",
                 kind_seen[KIND_PING], kind_seen[KIND_PONG], kind_seen[KIND_SUCCESS],
                 kind_seen[KIND_TIMEOUT], kind_seen[KIND_UNRESOLVED], kind_seen[KIND_OVERFLOW]);
        if (errors == 0 && awaited_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: echo_rtt_timeout_tracker_core.f
+incdir+rtl
rtl/ertt_pkg.sv
rtl/ertt_ram.sv
rtl/ertt_front.sv
rtl/ertt_back.sv
rtl/echo_rtt_timeout_tracker_core.sv
bench/echo_rtt_timeout_tracker_core_test.sv
